// ===== rtl/spl_pkg.sv =====
// Shared types, constants and fixed-point helpers for the specular lobe texel pipeline.
// No dependencies; every other file in rtl/ imports this package.
package spl_pkg;

  // Output scaling: results are fractions times (2^OUT_FRAC_BITS - 1)
  localparam int unsigned OUT_FRAC_BITS = 16;

  localparam int unsigned COMP_W     = 16;  // direction / light component width
  localparam int unsigned EXP_W      = 10;  // exponent register width
  localparam int unsigned SPEC_W     = 16;  // result field width
  localparam int unsigned N_CH       = 4;   // result channels
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Q1.31 cosine and rounding constants
  localparam logic [31:0] Q_ONE     = 32'h8000_0000;
  localparam logic [63:0] Q_HALF    = 64'h0000_0000_4000_0000;
  localparam logic [31:0] OUT_SCALE = 32'((64'd1 << OUT_FRAC_BITS) - 64'd1);
  localparam logic [SPEC_W-1:0] SPEC_MAX = '1;

  // Register reset values
  localparam logic [EXP_W-1:0]  EXP_A_RST   = 10'd2;
  localparam logic [EXP_W-1:0]  EXP_B_RST   = 10'd12;
  localparam logic [EXP_W-1:0]  EXP_C_RST   = 10'd50;
  localparam logic [EXP_W-1:0]  EXP_D_RST   = 10'd400;
  localparam logic [COMP_W-1:0] LIGHT_X_RST = 16'sd0;
  localparam logic [COMP_W-1:0] LIGHT_Y_RST = 16'sd16384;
  localparam logic [COMP_W-1:0] LIGHT_Z_RST = 16'sd0;

  // Pipeline layout
  localparam int unsigned SQ_STEPS = 31;        // one root bit per stage
  localparam int unsigned DV_STEPS = 31;        // one quotient bit per stage
  localparam int unsigned PW_STEPS = EXP_W;     // one exponent bit per stage
  localparam int unsigned ST_A     = 0;         // products
  localparam int unsigned ST_B     = 1;         // sums
  localparam int unsigned ST_C     = 2;         // normalize shift
  localparam int unsigned ST_SQ0   = 3;
  localparam int unsigned ST_DI    = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_DV0   = ST_DI + 1;
  localparam int unsigned ST_PW0   = ST_DV0 + DV_STEPS;
  localparam int unsigned ST_OUT   = ST_PW0 + PW_STEPS;
  localparam int unsigned NSTG     = ST_OUT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXP_A   = 3'd0,
    REG_EXP_B   = 3'd1,
    REG_EXP_C   = 3'd2,
    REG_EXP_D   = 3'd3,
    REG_LIGHT_X = 3'd4,
    REG_LIGHT_Y = 3'd5,
    REG_LIGHT_Z = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [SPEC_W-1:0] spec_a;
    logic [SPEC_W-1:0] spec_b;
    logic [SPEC_W-1:0] spec_c;
    logic [SPEC_W-1:0] spec_d;
  } spec_t;

  // Q1.31 multiply, rounded half up
  function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] t;
    t = ({32'd0, a} * {32'd0, b}) + Q_HALF;
    return t[62:31];
  endfunction

  // Q1.31 to output fraction with saturation
  function automatic logic [SPEC_W-1:0] to_out(input logic [31:0] p);
    logic [63:0] t;
    t = ({32'd0, p} * {32'd0, OUT_SCALE}) + Q_HALF;
    if (t[63:31] > 33'({SPEC_MAX})) begin
      return SPEC_MAX;
    end
    return t[31+SPEC_W-1:31];
  endfunction

endpackage

// ===== rtl/spl_dir_if.sv =====
// Direction word channel: valid/ready handshake carrying one cube-map direction.
// Depends on spl_pkg.
interface spl_dir_if;
  import spl_pkg::*;
  logic valid;
  logic ready;
  dir_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spl_spec_if.sv =====
// Result word channel: valid/ready handshake carrying four specular terms.
// Depends on spl_pkg.
interface spl_spec_if;
  import spl_pkg::*;
  logic  valid;
  logic  ready;
  spec_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/specular_lobe_texel.sv =====
// Specular lobe texel: normalized direction dot light, clamped, raised to four exponents.
// Throughput: one word per cycle while the skid slot is empty; the square root
// (31 stages), the divider (31 stages) and the exponent ladder (10 stages) are fully
// pipelined, one bit per stage.
// A two-entry output (register plus skid) keeps input ready registered.
// Reset (rst_ni low, async) empties the pipeline and loads default exponents and light.
module specular_lobe_texel (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  spl_dir_if.sink                          dir_i,
  spl_spec_if.source                       spec_o,
  input  logic                             cfg_we_i,
  input  logic [spl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import spl_pkg::*;

  // Carried alongside the root iterations
  typedef struct packed {
    logic        zero;  // all-zero direction
    logic        pos;   // dot product > 0
    logic [31:0] un;    // dot product magnitude (valid when pos)
    logic [4:0]  k;     // half of the normalize shift
  } side_t;

  // Divider stage word
  typedef struct packed {
    logic [30:0] s;
    logic [31:0] r;
    logic [30:0] q;
    logic [13:0] lo;
    logic        clamp;
    logic        zero;
    logic        pos;
  } dv_t;

  // Power ladder stage word
  typedef struct packed {
    logic [31:0]           base;
    logic [N_CH-1:0][31:0] acc;
    logic                  zero;
  } pw_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [N_CH-1:0][EXP_W-1:0] exp_q;
  logic signed [COMP_W-1:0]   light_x_q, light_y_q, light_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q     <= {EXP_D_RST, EXP_C_RST, EXP_B_RST, EXP_A_RST};
      light_x_q <= LIGHT_X_RST;
      light_y_q <= LIGHT_Y_RST;
      light_z_q <= LIGHT_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXP_A:   exp_q[0]  <= cfg_data_i[EXP_W-1:0];
        REG_EXP_B:   exp_q[1]  <= cfg_data_i[EXP_W-1:0];
        REG_EXP_C:   exp_q[2]  <= cfg_data_i[EXP_W-1:0];
        REG_EXP_D:   exp_q[3]  <= cfg_data_i[EXP_W-1:0];
        REG_LIGHT_X: light_x_q <= cfg_data_i[COMP_W-1:0];
        REG_LIGHT_Y: light_y_q <= cfg_data_i[COMP_W-1:0];
        REG_LIGHT_Z: light_z_q <= cfg_data_i[COMP_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: whole pipe moves while the skid slot is free
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic            skid_v_q, out_v_q;
  logic            en;
  logic            out_free;

  assign en          = !skid_v_q;
  assign out_free    = !out_v_q || spec_o.ready;
  assign dir_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], dir_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: dot-product terms and squares
  // ---------------------------------------------------------------------------
  logic signed [31:0] pa_x_q, pa_y_q, pa_z_q;
  logic [30:0]        sq_x_q, sq_y_q, sq_z_q;
  logic signed [31:0] sqx_w, sqy_w, sqz_w;

  assign sqx_w = dir_i.data.dir_x * dir_i.data.dir_x;
  assign sqy_w = dir_i.data.dir_y * dir_i.data.dir_y;
  assign sqz_w = dir_i.data.dir_z * dir_i.data.dir_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_x_q <= dir_i.data.dir_x * light_x_q;
      pa_y_q <= dir_i.data.dir_y * light_y_q;
      pa_z_q <= dir_i.data.dir_z * light_z_q;
      sq_x_q <= sqx_w[30:0];
      sq_y_q <= sqy_w[30:0];
      sq_z_q <= sqz_w[30:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: dot product n and squared length
  // ---------------------------------------------------------------------------
  logic signed [32:0] n_q;
  logic [31:0]        len_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q   <= {pa_x_q[31], pa_x_q} + {pa_y_q[31], pa_y_q} + {pa_z_q[31], pa_z_q};
      len_q <= {1'b0, sq_x_q} + {1'b0, sq_y_q} + {1'b0, sq_z_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: even left shift so the root input sits in [2^60, 2^62)
  // ---------------------------------------------------------------------------
  logic [61:0] c_m_q;
  side_t       c_sd_q;
  logic [4:0]  msb_w;
  logic [6:0]  km_w;
  side_t       c_sd_d;

  always_comb begin
    msb_w = '0;
    for (int i = 0; i < 32; i++) begin
      if (len_q[i]) msb_w = 5'(i);
    end
    km_w        = 7'd61 - {2'b00, msb_w};
    c_sd_d.k    = km_w[5:1];
    c_sd_d.zero = (len_q == '0);
    c_sd_d.pos  = !n_q[32] && (n_q != '0);
    c_sd_d.un   = n_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_m_q  <= {30'd0, len_q} << {c_sd_d.k, 1'b0};
      c_sd_q <= c_sd_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: one result bit per stage (bit weight 2^60 down to 2^0)
  // ---------------------------------------------------------------------------
  logic [SQ_STEPS-1:0][61:0] sq_v_q;
  logic [SQ_STEPS-1:0][61:0] sq_root_q;
  side_t [SQ_STEPS-1:0]      sq_sd_q;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * j);
    logic [61:0] v_in, root_in, v_out, root_out;
    side_t       sd_in;
    logic [62:0] trial;

    if (j == 0) begin : g_first
      assign v_in    = c_m_q;
      assign root_in = '0;
      assign sd_in   = c_sd_q;
    end else begin : g_next
      assign v_in    = sq_v_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign sd_in   = sq_sd_q[j-1];
    end

    always_comb begin
      trial = {1'b0, root_in} + {1'b0, BIT};
      if ({1'b0, v_in} >= trial) begin
        v_out    = v_in - trial[61:0];
        root_out = (root_in >> 1) + BIT;
      end else begin
        v_out    = v_in;
        root_out = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_v_q[j]    <= v_out;
        sq_root_q[j] <= root_out;
        sq_sd_q[j]   <= sd_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider setup (dv_q[0]) and 31 restoring steps (dv_q[1..31])
  // c = (un << (k+17)) / s, or one when un << k >= s << 14
  // ---------------------------------------------------------------------------
  dv_t [DV_STEPS:0] dv_q;
  logic [61:0]      a_w;
  logic [30:0]      s_w;
  side_t            di_sd_w;
  dv_t              di_d;

  assign s_w     = sq_root_q[SQ_STEPS-1][30:0];
  assign di_sd_w = sq_sd_q[SQ_STEPS-1];
  assign a_w     = {30'd0, di_sd_w.un} << di_sd_w.k;

  always_comb begin
    di_d.s     = s_w;
    di_d.r     = a_w[45:14];
    di_d.q     = '0;
    di_d.lo    = a_w[13:0];
    di_d.clamp = (a_w >= {17'd0, s_w, 14'd0});
    di_d.zero  = di_sd_w.zero;
    di_d.pos   = di_sd_w.pos;
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= di_d;
  end

  for (genvar t = 0; t < DV_STEPS; t++) begin : g_div
    logic        dbit;
    logic [31:0] rs;
    dv_t         nx;

    if (t <= 13) begin : g_lo
      assign dbit = dv_q[t].lo[13-t];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    always_comb begin
      nx = dv_q[t];
      rs = {dv_q[t].r[30:0], dbit};
      if (rs >= {1'b0, dv_q[t].s}) begin
        nx.r         = rs - {1'b0, dv_q[t].s};
        nx.q[30-t]   = 1'b1;
      end else begin
        nx.r         = rs;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[t+1] <= nx;
    end
  end

  // ---------------------------------------------------------------------------
  // Power ladder: square-and-multiply, LSB of each exponent first.
  // The squaring chain is shared by the four channels.
  // ---------------------------------------------------------------------------
  pw_t [PW_STEPS-1:0] pw_q;

  for (genvar j = 0; j < PW_STEPS; j++) begin : g_pow
    pw_t pin, pout;

    if (j == 0) begin : g_first
      always_comb begin
        pin.zero = dv_q[DV_STEPS].zero;
        if (!dv_q[DV_STEPS].pos) begin
          pin.base = '0;
        end else if (dv_q[DV_STEPS].clamp) begin
          pin.base = Q_ONE;
        end else begin
          pin.base = {1'b0, dv_q[DV_STEPS].q};
        end
        for (int ch = 0; ch < N_CH; ch++) pin.acc[ch] = Q_ONE;
      end
    end else begin : g_next
      assign pin = pw_q[j-1];
    end

    always_comb begin
      pout.zero = pin.zero;
      pout.base = qmul(pin.base, pin.base);
      for (int ch = 0; ch < N_CH; ch++) begin
        pout.acc[ch] = exp_q[ch][j] ? qmul(pin.acc[ch], pin.base) : pin.acc[ch];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) pw_q[j] <= pout;
    end
  end

  // ---------------------------------------------------------------------------
  // Output scaling, then output register with one skid entry
  // ---------------------------------------------------------------------------
  spec_t ot_q, ot_d, out_q, skid_q;

  always_comb begin
    if (pw_q[PW_STEPS-1].zero) begin
      ot_d = '0;
    end else begin
      ot_d.spec_a = to_out(pw_q[PW_STEPS-1].acc[0]);
      ot_d.spec_b = to_out(pw_q[PW_STEPS-1].acc[1]);
      ot_d.spec_c = to_out(pw_q[PW_STEPS-1].acc[2]);
      ot_d.spec_d = to_out(pw_q[PW_STEPS-1].acc[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) ot_q <= ot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (out_free) begin
        out_v_q <= v_q[NSTG-1];
      end else if (v_q[NSTG-1]) begin
        skid_v_q <= 1'b1;
      end
    end else if (out_free) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_free) begin
        out_q <= ot_q;
      end else begin
        skid_q <= ot_q;
      end
    end else if (out_free) begin
      out_q <= skid_q;
    end
  end

  assign spec_o.valid = out_v_q;
  assign spec_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held while output register empty");

  a_root_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_DI] && dv_q[0].pos) |-> dv_q[0].s[30])
    else $error("square root outside [2^30, 2^31)");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_PW0-1] && dv_q[DV_STEPS].pos && !dv_q[DV_STEPS].clamp)
      |-> (dv_q[DV_STEPS].r < {1'b0, dv_q[DV_STEPS].s}))
    else $error("divider remainder not below divisor");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_PW0] |-> (pw_q[0].base <= Q_ONE))
    else $error("cosine above one after clamp");

endmodule

// ===== verif/specular_lobe_texel_test.sv =====
// Self-checking bench for specular_lobe_texel: direction words in, specular words out.
// Depends on spl_pkg, spl_dir_if, spl_spec_if and the RTL top level.
// Expected words come from a bit-exact fixed-point predictor kept in this file.
`timescale 1ns / 100ps

module specular_lobe_texel_test;
  import spl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 100;   // pipeline is 78 deep
  localparam int unsigned IDLE_PCT    = 11;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  spl_dir_if  dir_ch ();
  spl_spec_if spec_ch ();

  specular_lobe_texel i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dir_i      (dir_ch),
    .spec_o     (spec_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers, tracked from our own writes
  logic [EXP_W-1:0]         exp_sh [N_CH];
  logic signed [COMP_W-1:0] lx_sh, ly_sh, lz_sh;

  spec_t spec_due_q [$];
  int unsigned err_cnt = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;

  // ---- predictor -------------------------------------------------------
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q1.31 product, rounded half up
  function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'h4000_0000) >> 31;
  endfunction

  function automatic logic [63:0] q31_pow(input logic [63:0] base, input logic [EXP_W-1:0] e);
    logic [63:0] acc;
    acc = 64'h8000_0000;
    while (e != 0) begin
      if (e[0]) acc = q31_mul(acc, base);
      base = q31_mul(base, base);
      e >>= 1;
    end
    return acc;
  endfunction

  function automatic logic [SPEC_W-1:0] frac_out(input logic [63:0] p);
    logic [63:0] r;
    r = (p * ((64'd1 << OUT_FRAC_BITS) - 1) + 64'h4000_0000) >> 31;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic spec_t predict_spec(input dir_t d);
    longint dx, dy, dz, dot;
    logic [63:0] len2, un, s, c;
    int unsigned k;
    spec_t o;
    dx = d.dir_x; dy = d.dir_y; dz = d.dir_z;
    dot = dx * longint'(lx_sh) + dy * longint'(ly_sh) + dz * longint'(lz_sh);
    len2 = dx * dx + dy * dy + dz * dz;
    c = 0;
    k = 0;
    if (len2 == 0) return '0;        // zero direction: all terms zero
    if (dot > 0) begin
      un = dot;
      while (k < 31 && (len2 << (2 * k)) < (64'd1 << 60)) k++;
      s = root_floor(len2 << (2 * k));
      // cosine above one when the light is longer than unit
      if ((un << k) >= (s << 14)) c = 64'h8000_0000;
      else c = (un << (k + 17)) / s;
    end
    o.spec_a = frac_out(q31_pow(c, exp_sh[0]));
    o.spec_b = frac_out(q31_pow(c, exp_sh[1]));
    o.spec_c = frac_out(q31_pow(c, exp_sh[2]));
    o.spec_d = frac_out(q31_pow(c, exp_sh[3]));
    return o;
  endfunction

  // ---- drivers -------------------------------------------------------------
  initial begin
    dir_ch.valid = 1'b0;
    dir_ch.data = '0;
    spec_ch.ready = 1'b0;
  end

  // Sink side: ready toggles on falling edges
  always @(negedge clk_i) begin
    if (rst_ni) spec_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  // Send one direction word; expectation is queued at the accepting edge
  task automatic send_dir(input dir_t w, input bit has_exp, input spec_t exp_w);
    spec_t pred;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      dir_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    dir_ch.valid <= 1'b1;
    dir_ch.data <= w;
    do @(posedge clk_i); while (!dir_ch.ready);
    pred = predict_spec(w);
    if (has_exp && pred != exp_w) begin
      $error("directed row: predictor %h disagrees with table %h", pred, exp_w);
      err_cnt++;
    end
    spec_due_q.push_back(has_exp ? exp_w : pred);
    @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    case (idx)
      REG_EXP_A:   exp_sh[0] = val[EXP_W-1:0];
      REG_EXP_B:   exp_sh[1] = val[EXP_W-1:0];
      REG_EXP_C:   exp_sh[2] = val[EXP_W-1:0];
      REG_EXP_D:   exp_sh[3] = val[EXP_W-1:0];
      REG_LIGHT_X: lx_sh = val;
      REG_LIGHT_Y: ly_sh = val;
      REG_LIGHT_Z: lz_sh = val;
      default: ;                     // index seven: ignored by the block
    endcase
  endtask

  // Write to the unused index seven; must leave every register alone
  task automatic write_spare(input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= '1;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic drain;
    dir_ch.valid <= 1'b0;
    while (spec_due_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [EXP_W-1:0] ea, eb, ec, ed,
                            input logic [15:0] x, y, z);
    drain();
    write_reg(REG_EXP_A, 16'(ea));
    write_reg(REG_EXP_B, 16'(eb));
    write_reg(REG_EXP_C, 16'(ec));
    write_reg(REG_EXP_D, 16'(ed));
    write_reg(REG_LIGHT_X, x);
    write_reg(REG_LIGHT_Y, y);
    write_reg(REG_LIGHT_Z, z);
    write_spare(16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Random direction; leans toward the light so high exponents see nonzero terms
  function automatic dir_t rand_dir();
    dir_t d;
    int unsigned pick;
    int sc;
    pick = $urandom_range(99);
    if (pick < 15) begin
      d = dir_t'({16'($urandom), 16'($urandom), 16'($urandom)});
    end else if (pick < 45) begin
      sc = $urandom_range(3);
      d.dir_x = (lx_sh >>> sc) + 16'($signed($urandom_range(64)) - 32);
      d.dir_y = (ly_sh >>> sc) + 16'($signed($urandom_range(64)) - 32);
      d.dir_z = (lz_sh >>> sc) + 16'($signed($urandom_range(64)) - 32);
    end else if (pick < 55) begin
      d.dir_x = 16'($signed($urandom_range(8)) - 4);
      d.dir_y = 16'($signed($urandom_range(8)) - 4);
      d.dir_z = 16'($signed($urandom_range(8)) - 4);
    end else begin
      d.dir_x = 16'($signed($urandom_range(32768)) - 16384);
      d.dir_y = 16'($signed($urandom_range(32768)) - 16384);
      d.dir_z = 16'($signed($urandom_range(32768)) - 16384);
    end
    return d;
  endfunction

  // ---- result checker ----------------------------------------------------
  always @(posedge clk_i) begin
    spec_t got, want;
    if (rst_ni && spec_ch.valid && spec_ch.ready) begin
      got = spec_ch.data;
      if (spec_due_q.size() == 0) begin
        $error("unexpected result word %h", got);
        err_cnt++;
      end else begin
        want = spec_due_q.pop_front();
        if (got.spec_a !== want.spec_a) begin
          $error("spec_a expected %0d actual %0d", want.spec_a, got.spec_a);
          err_cnt++;
        end
        if (got.spec_b !== want.spec_b) begin
          $error("spec_b expected %0d actual %0d", want.spec_b, got.spec_b);
          err_cnt++;
        end
        if (got.spec_c !== want.spec_c) begin
          $error("spec_c expected %0d actual %0d", want.spec_c, got.spec_c);
          err_cnt++;
        end
        if (got.spec_d !== want.spec_d) begin
          $error("spec_d expected %0d actual %0d", want.spec_d, got.spec_d);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- directed table (reset config: light along +y, exps 2/12/50/400) ----
  typedef struct {
    dir_t  d;
    bit    known;     // expected word typed in below
    spec_t want;
  } dir_row_t;

  localparam spec_t ALL_ZERO = '0;
  localparam spec_t ALL_FULL = '1;

  dir_row_t rows [] = '{
    '{dir_t'({16'sd0, 16'sd0, 16'sd0}),                1, ALL_ZERO}, // zero direction
    '{dir_t'({16'sd0, 16'sd16384, 16'sd0}),            1, ALL_FULL}, // on the light
    '{dir_t'({16'sd0, -16'sd16384, 16'sd0}),           1, ALL_ZERO}, // facing away
    '{dir_t'({16'sd16384, 16'sd0, 16'sd0}),            1, ALL_ZERO}, // dot is zero
    '{dir_t'({16'sd0, 16'sd1, 16'sd0}),                1, ALL_FULL}, // tiny length
    '{dir_t'({16'sd0, 16'sd32767, 16'sd0}),            1, ALL_FULL}, // out of range +
    '{dir_t'({16'sd0, 16'h8000, 16'sd0}),              1, ALL_ZERO}, // out of range -
    '{dir_t'({-16'sd16384, -16'sd16384, -16'sd16384}), 1, ALL_ZERO},
    '{dir_t'({16'sd16384, 16'sd16384, 16'sd0}),        0, ALL_ZERO},
    '{dir_t'({16'sd16384, 16'sd16384, 16'sd16384}),    0, ALL_ZERO},
    '{dir_t'({16'sd0, 16'sd16384, 16'sd16384}),        0, ALL_ZERO},
    '{dir_t'({16'sd1, 16'sd1, 16'sd1}),                0, ALL_ZERO},
    '{dir_t'({16'sd32767, 16'sd32767, 16'sd32767}),    0, ALL_ZERO},
    '{dir_t'({16'h8000, 16'sd100, 16'h8000}),          0, ALL_ZERO},
    '{dir_t'({16'sd3, 16'sd400, -16'sd7}),             0, ALL_ZERO}
  };

  initial begin
    exp_sh[0] = EXP_A_RST; exp_sh[1] = EXP_B_RST;
    exp_sh[2] = EXP_C_RST; exp_sh[3] = EXP_D_RST;
    lx_sh = LIGHT_X_RST; ly_sh = LIGHT_Y_RST; lz_sh = LIGHT_Z_RST;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_dir(rows[i].d, rows[i].known, rows[i].want);

    // Phases: extremes first, then random settings; one phase with no idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(10'd1, 10'd1023, 10'd0, 10'd7, 16'sd16384, 16'sd0, 16'sd0);
        1: set_config(10'd1023, 10'd1, 10'd3, 10'd0, 16'sd0, 16'sd0, -16'sd16384);
        2: set_config(10'd2, 10'd5, 10'd9, 10'd33, 16'sd16384, 16'sd16384, 16'sd16384);
        3: set_config(10'd0, 10'd0, 10'd1023, 10'd1023, -16'sd16384, -16'sd16384, 16'sd0);
        default: set_config(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                            16'($signed($urandom_range(32768)) - 16384),
                            16'($signed($urandom_range(32768)) - 16384),
                            16'($signed($urandom_range(32768)) - 16384));
      endcase
      idle_on = (ph != 2);
      repeat (165) send_dir(rand_dir(), 1'b0, ALL_ZERO);
    end
    idle_on = 1'b1;
    drain();

    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
